>>> rtl/core/tmps_pkg.sv
`default_nettype none

package tmps_pkg;

    // Fixed field widths of the stream and register interface
    localparam int VALUE_W     = 16;
    localparam int MIN_SUM_W   = 24;
    localparam int ROW_COUNT_W = 9;
    localparam int SUM_MIN_W   = 25;

    // Output saturation limits (24-bit two's complement)
    localparam int MIN_SUM_MAX = 8388607;
    localparam int MIN_SUM_MIN = -8388608;

    // Register word index
    localparam logic [1:0] REG_ROW_COUNT = 2'd0;

    // Broadcast control for the sum chain
    typedef struct packed {
        logic push;   // write the new sum at the tail
        logic pop;    // every cell but the write slot takes its upstream neighbor's sum
    } chain_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/triangle_min_path_sum.sv
// min_sum is registered and appears on m_tdata in the cycle after the final entry's transfer.
// Throughput: one entry per cycle; the partial-sum queue takes one new sum per entry.
// The input stalls only when a result is due while the previous one still waits.
// Reset (rst_n low, asynchronous): row_count returns to 1, the triangle restarts
// at the apex and the output is empty; queue contents are not cleared.
`default_nettype none

module triangle_min_path_sum #(
    parameter int MAX_ROWS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] value
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,    // [23:0] min_sum
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = $clog2(MAX_ROWS + 1);
    localparam int EW    = (CW > tmps_pkg::ROW_COUNT_W) ? CW : tmps_pkg::ROW_COUNT_W;
    localparam int SW_G  = tmps_pkg::VALUE_W + RW + 1;
    localparam int SW    = (SW_G > tmps_pkg::SUM_MIN_W) ? SW_G : tmps_pkg::SUM_MIN_W;
    localparam int OW    = tmps_pkg::MIN_SUM_W;
    localparam int VW    = tmps_pkg::VALUE_W;

    localparam logic signed [SW-1:0] SAT_HI = SW'(tmps_pkg::MIN_SUM_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(tmps_pkg::MIN_SUM_MIN);

    // Registers
    logic [tmps_pkg::ROW_COUNT_W-1:0] row_count_reg, row_count_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic [RW-1:0]                    col_reg, col_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic signed [SW-1:0]             left_reg, left_next;
    logic signed [SW-1:0]             best_reg, best_next;
    logic                             out_valid_reg, out_valid_next;
    logic [OW-1:0]                    out_data_reg, out_data_next;

    // Datapath and control
    logic                             cfg_wr;
    logic [EW-1:0]                    rows_raw;
    logic [EW-1:0]                    rows_eff;
    logic                             last_row;
    logic                             at_edge;
    logic                             emit;
    logic                             accept;
    logic signed [SW-1:0]             v_ext;
    logic signed [SW-1:0]             above;
    logic signed [SW-1:0]             pick;
    logic signed [SW-1:0]             s_sum;
    logic [OW-1:0]                    sat_sum;
    logic [CW-1:0]                    wr_pos_full;
    tmps_pkg::chain_ctl_t             ctl;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == tmps_pkg::REG_ROW_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr == tmps_pkg::REG_ROW_COUNT)
        begin
            prdata = 32'(row_count_reg);
        end
    end

    // Effective row count: zero means one, capped at the queue depth
    always_comb
    begin
        rows_raw = EW'(row_count_reg);
        rows_eff = rows_raw;
        if (rows_raw == '0)
        begin
            rows_eff = EW'(1);
        end
        else if (rows_raw > EW'(MAX_ROWS))
        begin
            rows_eff = EW'(MAX_ROWS);
        end
    end

    assign last_row = (EW'(row_reg) + EW'(1)) >= rows_eff;
    assign at_edge  = (col_reg == row_reg);
    assign emit     = at_edge && last_row;

    // Stall only a result-producing entry while the output is full
    assign s_tready = !(emit && out_valid_reg && !m_tready);
    assign accept   = s_tvalid && s_tready;

    // Sum of the entry and its cheaper upper neighbor (the entry alone in the top row)
    assign v_ext = {{(SW - VW){s_tdata[VW-1]}}, s_tdata};

    always_comb
    begin
        if (row_reg == '0)
        begin
            pick = '0;
        end
        else if (col_reg == '0)
        begin
            pick = above;
        end
        else if (at_edge)
        begin
            pick = left_reg;
        end
        else
        begin
            pick = (left_reg < above) ? left_reg : above;
        end
        s_sum = v_ext + pick;
    end

    // Queue control: pop on entries with an upper-right neighbor
    assign ctl.push    = accept;
    assign ctl.pop     = accept && (row_reg != '0) && !at_edge;
    assign wr_pos_full = ctl.pop ? (count_reg - CW'(1)) : count_reg;

    tmps_chain #(
        .DEPTH (MAX_ROWS),
        .SUM_W (SW),
        .IDX_W (RW)
    ) u_chain (
        .clk      (clk),
        .ctl      (ctl),
        .wr_pos   (wr_pos_full[RW-1:0]),
        .new_sum  (s_sum),
        .head_sum (above)
    );

    // Running minimum of the last row and saturation
    always_comb
    begin
        best_next = best_reg;
        if (accept && last_row)
        begin
            if (col_reg == '0)
            begin
                best_next = s_sum;
            end
            else
            begin
                best_next = (s_sum < best_reg) ? s_sum : best_reg;
            end
        end

        if (best_next > SAT_HI)
        begin
            sat_sum = SAT_HI[OW-1:0];
        end
        else if (best_next < SAT_LO)
        begin
            sat_sum = SAT_LO[OW-1:0];
        end
        else
        begin
            sat_sum = best_next[OW-1:0];
        end
    end

    // Position tracking and queue occupancy
    always_comb
    begin
        row_count_next = row_count_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        count_next     = count_reg;
        left_next      = left_reg;

        if (accept)
        begin
            left_next = above;
            if (at_edge)
            begin
                col_next = '0;
                row_next = last_row ? '0 : (row_reg + RW'(1));
            end
            else
            begin
                col_next = col_reg + RW'(1);
            end

            if (emit)
            begin
                count_next = '0;
            end
            else if (!ctl.pop)
            begin
                count_next = count_reg + CW'(1);
            end
        end

        if (cfg_wr)
        begin
            row_count_next = pwdata[tmps_pkg::ROW_COUNT_W-1:0];
            row_next       = '0;
            col_next       = '0;
            count_next     = '0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sat_sum;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= tmps_pkg::ROW_COUNT_W'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ROWS))
        else $error("queue occupancy above depth");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= row_reg)
        else $error("column beyond row");

    a_row_start_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg == '0) |-> (count_reg == CW'(row_reg)))
        else $error("queue does not hold the row above at row start");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |-> (!out_valid_reg || m_tready))
        else $error("result accepted into a full output");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (m_tvalid && (m_tdata == $past(sat_sum))))
        else $error("result not presented after final entry");

endmodule

`default_nettype wire

>>> rtl/core/tmps_cell.sv
`default_nettype none

// One slot of the partial-sum queue. Takes the new sum when it is the
// write slot, otherwise the neighbor's sum when the queue advances.
module tmps_cell #(
    parameter int SUM_W = 25,
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  wire logic                    clk,
    input  wire tmps_pkg::chain_ctl_t    ctl,
    input  wire logic [IDX_W-1:0]        wr_pos,
    input  wire logic [SUM_W-1:0]        new_sum,
    input  wire logic [SUM_W-1:0]        up_sum,
    output logic      [SUM_W-1:0]        sum
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             wr_sel;

    assign wr_sel = ctl.push && (wr_pos == IDX_W'(INDEX));

    // Slot update
    always_comb
    begin
        sum_next = sum_reg;
        if (wr_sel)
        begin
            sum_next = new_sum;
        end
        else if (ctl.pop)
        begin
            sum_next = up_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

>>> rtl/core/tmps_chain.sv
`default_nettype none

// Queue of partial sums of the row above, built as a shifting row of cells.
// The head cell holds the upper-right neighbor of the next entry whenever it has one.
module tmps_chain #(
    parameter int DEPTH = 256,
    parameter int SUM_W = 25,
    parameter int IDX_W = 8
) (
    input  wire logic                    clk,
    input  wire tmps_pkg::chain_ctl_t    ctl,
    input  wire logic [IDX_W-1:0]        wr_pos,
    input  wire logic [SUM_W-1:0]        new_sum,
    output logic      [SUM_W-1:0]        head_sum
);

    logic [SUM_W-1:0] sums [DEPTH];
    logic [SUM_W-1:0] ups  [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            // Neighbor feed; the tail end takes zeros
            if (i == DEPTH - 1)
            begin : g_tail
                assign ups[i] = '0;
            end
            else
            begin : g_mid
                assign ups[i] = sums[i+1];
            end

            tmps_cell #(
                .SUM_W (SUM_W),
                .IDX_W (IDX_W),
                .INDEX (i)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .wr_pos  (wr_pos),
                .new_sum (new_sum),
                .up_sum  (ups[i]),
                .sum     (sums[i])
            );
        end
    endgenerate

    assign head_sum = sums[0];

endmodule

`default_nettype wire

>>> verif/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS    = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 530;

    // Directed stimulus: a config write or one triangle entry
    typedef enum logic {DIR_CFG, DIR_VALUE} dir_op_t;

    typedef struct packed {
        dir_op_t     op;
        logic [15:0] data;     // entry value, or row_count in [8:0]
        logic        typed;    // min_sum below is known by hand
        logic [23:0] want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // single-row triangles after reset: the entry is the sum
        '{DIR_VALUE, 16'h0005, 1'b1, 24'h000005},
        '{DIR_VALUE, 16'h8000, 1'b1, 24'hFF8000},
        '{DIR_VALUE, 16'h7FFF, 1'b1, 24'h007FFF},
        // zero row count acts as one row
        '{DIR_CFG,   16'd0,    1'b0, 24'h0},
        '{DIR_VALUE, 16'hFFFF, 1'b1, 24'hFFFFFF},
        // two rows: 1 / 2 3
        '{DIR_CFG,   16'd2,    1'b0, 24'h0},
        '{DIR_VALUE, 16'h0001, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0002, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0003, 1'b1, 24'h000003},
        // three rows, inner entry picks the smaller neighbor
        '{DIR_CFG,   16'd3,    1'b0, 24'h0},
        '{DIR_VALUE, 16'h0002, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0003, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0004, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0006, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0005, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0007, 1'b0, 24'h0},
        // extreme entries
        '{DIR_CFG,   16'd2,    1'b0, 24'h0},
        '{DIR_VALUE, 16'h8000, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h8000, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h7FFF, 1'b0, 24'h0},
        // partial triangle, then a write restarts at the apex
        '{DIR_CFG,   16'd3,    1'b0, 24'h0},
        '{DIR_VALUE, 16'h0009, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0009, 1'b0, 24'h0},
        '{DIR_CFG,   16'd2,    1'b0, 24'h0},
        '{DIR_VALUE, 16'h0004, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0001, 1'b0, 24'h0},
        '{DIR_VALUE, 16'h0001, 1'b1, 24'h000005}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [23:0] m_tdata;
    wire logic [31:0] prdata;
    wire logic        pready;

    triangle_min_path_sum #(.MAX_ROWS(MAX_ROWS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),      // [15:0] value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),      // [23:0] min_sum
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Path-sum tracker state
    logic [8:0]        row_count_cfg = 9'd1;
    logic signed [24:0] row_sums [MAX_ROWS];
    int                row_ix = 0;
    int                col_ix = 0;
    logic signed [24:0] left_old = '0;
    logic signed [24:0] best_sum = '0;

    logic [23:0] min_sum_q [$];
    int          errors      = 0;
    int          cycles      = 0;
    int          burst_left  = 0;
    int          stall_mode  = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int rows_in_use(input logic [8:0] cnt);
        if (cnt == 0)
            return 1;
        if (cnt > MAX_ROWS)
            return MAX_ROWS;
        return int'(cnt);
    endfunction

    // Advance the path sums by one entry; flags a min_sum at triangle end
    function automatic void track_entry(input logic [15:0] raw, output bit got,
                                        output logic [23:0] res);
        logic signed [24:0] v;
        logic signed [24:0] above;
        logic signed [24:0] s;
        logic signed [24:0] sat;
        int rows;
        int r;
        int c;
        bit last;
        v = {{9{raw[15]}}, raw};
        rows = rows_in_use(row_count_cfg);
        r = row_ix;
        c = col_ix;
        if (r >= MAX_ROWS || c > r)
        begin
            r = 0;
            c = 0;
        end
        above = row_sums[c];
        if (r == 0)
            s = v;
        else if (c == 0)
            s = v + above;
        else if (c == r)
            s = v + left_old;
        else
            s = v + ((left_old < above) ? left_old : above);
        left_old = above;
        row_sums[c] = s;
        last = (r + 1 >= rows);
        if (last)
            best_sum = (c == 0 || s < best_sum) ? s : best_sum;
        got = 1'b0;
        res = '0;
        if (c == r)
        begin
            col_ix = 0;
            if (last)
            begin
                row_ix = 0;
                sat = best_sum;
                if (sat > tmps_pkg::MIN_SUM_MAX)
                    sat = 25'(tmps_pkg::MIN_SUM_MAX);
                if (sat < tmps_pkg::MIN_SUM_MIN)
                    sat = 25'(tmps_pkg::MIN_SUM_MIN);
                res = sat[23:0];
                got = 1'b1;
            end
            else
                row_ix = r + 1;
        end
        else
        begin
            row_ix = r;
            col_ix = c + 1;
        end
    endfunction

    // One entry transfer, with bursty gaps between runs of entries
    task automatic send_value(input logic [15:0] v, input logic typed,
                              input logic [23:0] want);
        int gap;
        bit got;
        logic [23:0] pred;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        burst_left--;
        track_entry(v, got, pred);
        if (got)
            min_sum_q.insert(min_sum_q.size(), typed ? want : pred);
    endtask

    // Write row_count once the block has drained, then read it back
    task automatic write_row_count(input logic [8:0] cnt);
        logic [31:0] wd;
        s_tvalid <= 1'b0;
        while (min_sum_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        wd = $urandom();
        wd[8:0] = cnt;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tmps_pkg::REG_ROW_COUNT;
        pwdata  <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        row_count_cfg = cnt;
        row_ix = 0;
        col_ix = 0;
        // read-back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        if (prdata !== {23'b0, cnt})
        begin
            errors++;
            $display("%0t: row_count read-back mismatch, expected %0d, got %0d",
                     $time, cnt, prdata);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output check, sampled mid-cycle ahead of the transfer edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (min_sum_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected min_sum transfer, expected none, got %0d",
                         $time, $signed(m_tdata));
            end
            else if (m_tdata !== min_sum_q[0])
            begin
                errors++;
                $display("%0t: min_sum mismatch, expected %0d, got %0d",
                         $time, $signed(min_sum_q[0]), $signed(m_tdata));
                void'(min_sum_q.pop_front());
            end
            else
                void'(min_sum_q.pop_front());
        end
    end

    // Receiver stall pattern and watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 400 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ((cycles % 7) < 3);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int rows;
        int total;
        int n;
        int tri_cnt;
        int rand_items;
        bit paused;
        logic [8:0]  cnt;
        logic [15:0] v;
        foreach (row_sums[i])
            row_sums[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIR_TAB[i])
        begin
            if (DIR_TAB[i].op == DIR_CFG)
                write_row_count(DIR_TAB[i].data[8:0]);
            else
                send_value(DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // random triangles, mostly small, some cut short by a restart
        rand_items = 0;
        paused = 1'b0;
        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 15))
                0: cnt = 9'd0;
                1: cnt = 9'd1;
                2: cnt = 9'($urandom_range(9, 24));
                3: cnt = 9'($urandom_range(25, 511));
                default: cnt = 9'($urandom_range(2, 8));
            endcase
            write_row_count(cnt);
            rows = rows_in_use(cnt);
            total = rows * (rows + 1) / 2;
            tri_cnt = $urandom_range(1, 4);
            for (int t = 0; t < tri_cnt && rand_items < RAND_ITEMS; t++)
            begin
                n = total;
                if (total > 1 && $urandom_range(0, 9) == 0)
                    n = $urandom_range(1, total - 1);
                // large triangles are only started, then restarted
                if (n > 120)
                    n = $urandom_range(1, 120);
                for (int k = 0; k < n; k++)
                begin
                    // hold the input once until the output has drained
                    if (!paused && rand_items > RAND_ITEMS / 2)
                    begin
                        s_tvalid <= 1'b0;
                        @(posedge clk);
                        while (min_sum_q.size() != 0)
                            @(posedge clk);
                        paused = 1'b1;
                    end
                    case ($urandom_range(0, 9))
                        0: v = 16'h8000;
                        1: v = 16'h7FFF;
                        2: v = 16'($signed($urandom_range(0, 40)) - 20);
                        default: v = 16'($urandom());
                    endcase
                    send_value(v, 1'b0, '0);
                    rand_items++;
                end
                if (n < total)
                    break;
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (min_sum_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/tmps_pkg.sv
rtl/core/tmps_cell.sv
rtl/core/tmps_chain.sv
rtl/core/triangle_min_path_sum.sv
verif/tb.sv
